// ===== rtl/cv2d_pkg.sv =====
`default_nettype none
package cv2d_pkg;

   // fixed pixel format
   localparam int PIXEL_BITS = 8;
   localparam int PIX_MAX    = (1 << PIXEL_BITS) - 1;

   // defaults for the top-level parameters
   localparam int DEF_MAX_KSIZE = 5;
   localparam int DEF_MAX_COLS  = 1024;
   localparam int DEF_MAX_ROWS  = 1024;
   localparam int DEF_FRAC_BITS = 6;

   // register port
   localparam int CFG_AW = 6;
   localparam int CFG_DW = 64;
   localparam int KWORDS = 4;
   localparam int DIM_W  = 11;
   localparam int KSZ_W  = 3;

   // signed products and sums (25 products of 16 bits fit easily)
   localparam int PROD_W = 16;
   localparam int ACC_W  = 24;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_ROWS  = 2'd1,
      ST_BAD_COLS  = 2'd2,
      ST_BAD_KSIZE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_NUM_ROWS = 3'd0,
      REG_NUM_COLS = 3'd1,
      REG_KSIZE    = 3'd2,
      REG_KWORD0   = 3'd3,
      REG_KWORD1   = 3'd4,
      REG_KWORD2   = 3'd5,
      REG_KWORD3   = 3'd6
   } reg_index_type;

   // control that travels with each window column
   typedef struct packed {
      logic       err;
      status_type status;
      logic       last;
      logic       emit;
      logic       first;
   } col_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/cv2d_ram.sv =====
`default_nettype none
module cv2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/cv2d_csr.sv =====
`default_nettype none
module cv2d_csr #(
   parameter int MAX_KSIZE = cv2d_pkg::DEF_MAX_KSIZE
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [cv2d_pkg::CFG_AW-1:0]  csr_paddr,
   input  wire logic [cv2d_pkg::CFG_DW-1:0]  csr_pwdata,
   output logic      [cv2d_pkg::CFG_DW-1:0]  csr_prdata,
   output logic                              csr_pready,
   output logic      [cv2d_pkg::DIM_W-1:0]   num_rows,
   output logic      [cv2d_pkg::DIM_W-1:0]   num_cols,
   output logic      [cv2d_pkg::KSZ_W-1:0]   ksize,
   output logic signed [7:0]                 coef [MAX_KSIZE][MAX_KSIZE]
);
   import cv2d_pkg::*;

   localparam int NB = MAX_KSIZE;

   logic [DIM_W-1:0]  num_rows_ff, num_rows_in;
   logic [DIM_W-1:0]  num_cols_ff, num_cols_in;
   logic [KSZ_W-1:0]  ksize_ff, ksize_in;
   logic [CFG_DW-1:0] kword_ff [KWORDS];
   logic [CFG_DW-1:0] kword_in [KWORDS];
   logic signed [7:0] coef_ff [NB][NB];
   logic signed [7:0] coef_in [NB][NB];
   logic              wr;
   reg_index_type     idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = reg_index_type'(csr_paddr[CFG_AW-1:3]);

   // register writes
   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      ksize_in    = ksize_ff;
      kword_in    = kword_ff;
      if (wr) begin
         unique case (idx)
            REG_NUM_ROWS: num_rows_in = csr_pwdata[DIM_W-1:0];
            REG_NUM_COLS: num_cols_in = csr_pwdata[DIM_W-1:0];
            REG_KSIZE:    ksize_in    = csr_pwdata[KSZ_W-1:0];
            REG_KWORD0:   kword_in[0] = csr_pwdata;
            REG_KWORD1:   kword_in[1] = csr_pwdata;
            REG_KWORD2:   kword_in[2] = csr_pwdata;
            REG_KWORD3:   kword_in[3] = csr_pwdata;
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (idx)
         REG_NUM_ROWS: csr_prdata = CFG_DW'(num_rows_ff);
         REG_NUM_COLS: csr_prdata = CFG_DW'(num_cols_ff);
         REG_KSIZE:    csr_prdata = CFG_DW'(ksize_ff);
         REG_KWORD0:   csr_prdata = kword_ff[0];
         REG_KWORD1:   csr_prdata = kword_ff[1];
         REG_KWORD2:   csr_prdata = kword_ff[2];
         REG_KWORD3:   csr_prdata = kword_ff[3];
         default:      csr_prdata = '0;
      endcase
   end

   // coefficient matrix indexed by row age i and column age j
   always_comb begin
      logic [KSZ_W-1:0] kr;
      logic [KSZ_W-1:0] kc;
      logic [5:0]       cidx;
      for (int i = 0; i < NB; i++) begin
         for (int j = 0; j < NB; j++) begin
            kr   = ksize_ff - KSZ_W'(i) - KSZ_W'(1);
            kc   = ksize_ff - KSZ_W'(j) - KSZ_W'(1);
            cidx = 6'(kr) * 6'(ksize_ff) + 6'(kc);
            if (KSZ_W'(i) < ksize_ff && KSZ_W'(j) < ksize_ff) begin
               coef_in[i][j] = kword_ff[cidx[4:3]][{cidx[2:0], 3'b000} +: 8];
            end else begin
               coef_in[i][j] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= DIM_W'(1);
         num_cols_ff <= DIM_W'(1);
         ksize_ff    <= KSZ_W'(1);
         for (int w = 0; w < KWORDS; w++) begin
            kword_ff[w] <= '0;
         end
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
         ksize_ff    <= ksize_in;
         kword_ff    <= kword_in;
      end
      coef_ff <= coef_in;
   end

   assign num_rows = num_rows_ff;
   assign num_cols = num_cols_ff;
   assign ksize    = ksize_ff;
   assign coef     = coef_ff;

endmodule
`default_nettype wire

// ===== rtl/cv2d_seq.sv =====
`default_nettype none
module cv2d_seq #(
   parameter int MAX_KSIZE = cv2d_pkg::DEF_MAX_KSIZE,
   parameter int MAX_COLS  = cv2d_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS  = cv2d_pkg::DEF_MAX_ROWS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,
   input  wire logic                       req_tuser,
   input  wire logic [cv2d_pkg::DIM_W-1:0] num_rows,
   input  wire logic [cv2d_pkg::DIM_W-1:0] num_cols,
   input  wire logic [cv2d_pkg::KSZ_W-1:0] ksize,
   output logic                            col_valid,
   input  wire logic                       col_ready,
   output cv2d_pkg::col_ctl_type           col_ctl,
   output logic [7:0]                      col_pix [MAX_KSIZE]
);
   import cv2d_pkg::*;

   localparam int NB = MAX_KSIZE;
   localparam int AW = $clog2(MAX_COLS);
   localparam int CW = $clog2(MAX_COLS + MAX_KSIZE + 1);
   localparam int RW = $clog2(MAX_ROWS + MAX_KSIZE + 1);
   localparam int BW = (NB > 1) ? $clog2(NB) : 1;

   // position and flush state
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [BW-1:0]    wb_ff, wb_in;
   logic [KSZ_W-1:0] flush_cnt_ff, flush_cnt_in;
   logic [CW-1:0]    flush_v_ff, flush_v_in;
   logic [RW-1:0]    flush_row_ff, flush_row_in;

   // read stage
   logic             b_valid_ff, b_valid_in;
   col_ctl_type      b_ctl_ff, b_ctl_in;
   logic [7:0]       b_pix_ff, b_pix_in;
   logic [NB-1:0]    b_mask_ff, b_mask_in;
   logic [BW-1:0]    b_wb_ff, b_wb_in;
   logic             b_zero_ff, b_zero_in;

   logic             b_ready;
   logic             issue_item;
   logic             issue_flush;
   status_type       status;
   logic             err;
   logic [KSZ_W-1:0] tail;
   logic             pos_reset;
   logic [RW-1:0]    row_eff;
   logic [CW-1:0]    col_eff;
   logic [BW-1:0]    wb_eff;
   logic             last_col;
   logic [7:0]       wpix;
   logic [RW-1:0]    row_next;
   logic [7:0]       rd [NB];

   assign b_ready     = !b_valid_ff || col_ready;
   assign req_tready  = b_ready && (flush_cnt_ff == '0);
   assign issue_item  = req_tvalid && req_tready;
   assign issue_flush = b_ready && (flush_cnt_ff != '0);

   // size checks, first failing one wins
   always_comb begin
      if (num_rows == '0 || num_rows > DIM_W'(MAX_ROWS)) begin
         status = ST_BAD_ROWS;
      end else if (num_cols == '0 || num_cols > DIM_W'(MAX_COLS)) begin
         status = ST_BAD_COLS;
      end else if (ksize == '0 || ksize > KSZ_W'(MAX_KSIZE)) begin
         status = ST_BAD_KSIZE;
      end else begin
         status = ST_OK;
      end
   end

   assign err  = (status != ST_OK);
   assign tail = ksize >> 1;

   // effective position: out-of-frame positions start a new frame
   always_comb begin
      pos_reset = (col_ff >= CW'(num_cols)) ||
                  (row_ff >= RW'(num_rows) + RW'(tail));
      col_eff   = pos_reset ? '0 : col_ff;
      row_eff   = pos_reset ? '0 : row_ff;
      wb_eff    = (col_eff == '0 && row_eff == '0) ? '0 : wb_ff;
      last_col  = (col_eff == CW'(num_cols - DIM_W'(1)));
      wpix      = (!req_tuser && row_eff < RW'(num_rows)) ? req_tdata : '0;
      row_next  = row_eff + RW'(1);
   end

   // position update and flush columns at the end of each output row
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      wb_in        = wb_ff;
      flush_cnt_in = flush_cnt_ff;
      flush_v_in   = flush_v_ff;
      flush_row_in = flush_row_ff;
      if (issue_item) begin
         if (err) begin
            row_in = '0;
            col_in = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = (row_next >= RW'(num_rows) + RW'(tail)) ? '0 : row_next;
            wb_in  = (wb_eff == BW'(NB - 1)) ? '0 : wb_eff + BW'(1);
            if (row_eff >= RW'(tail) && tail != '0) begin
               flush_cnt_in = tail;
               flush_v_in   = CW'(num_cols);
               flush_row_in = row_eff;
            end
         end else begin
            col_in = col_eff + CW'(1);
            row_in = row_eff;
            wb_in  = wb_eff;
         end
      end
      if (issue_flush) begin
         flush_cnt_in = flush_cnt_ff - KSZ_W'(1);
         flush_v_in   = flush_v_ff + CW'(1);
      end
   end

   // read stage load
   always_comb begin
      b_valid_in = b_valid_ff;
      b_ctl_in   = b_ctl_ff;
      b_pix_in   = b_pix_ff;
      b_mask_in  = b_mask_ff;
      b_wb_in    = b_wb_ff;
      b_zero_in  = b_zero_ff;
      if (b_ready) begin
         b_valid_in = issue_item || issue_flush;
         if (issue_flush) begin
            b_ctl_in.err    = 1'b0;
            b_ctl_in.status = ST_OK;
            b_ctl_in.emit   = (flush_v_ff >= CW'(tail));
            b_ctl_in.last   =
               (flush_row_ff - RW'(tail) == RW'(num_rows) - RW'(1)) &&
               (flush_v_ff - CW'(tail) == CW'(num_cols) - CW'(1));
            b_ctl_in.first  = 1'b0;
            b_zero_in       = 1'b1;
         end else begin
            b_ctl_in.err    = err;
            b_ctl_in.status = status;
            b_ctl_in.emit   = (row_eff >= RW'(tail)) && (col_eff >= CW'(tail));
            b_ctl_in.last   =
               (row_eff - RW'(tail) == RW'(num_rows) - RW'(1)) &&
               (col_eff - CW'(tail) == CW'(num_cols) - CW'(1));
            b_ctl_in.first  = (col_eff == '0);
            b_zero_in       = 1'b0;
         end
         b_pix_in = wpix;
         b_wb_in  = wb_eff;
         for (int i = 0; i < NB; i++) begin
            b_mask_in[i] = (KSZ_W'(i) < ksize) && (RW'(i) <= row_eff);
         end
      end
   end

   // line store: one bank per row modulo MAX_KSIZE
   for (genvar g = 0; g < NB; g++) begin : g_bank
      cv2d_ram #(
         .WIDTH (PIXEL_BITS),
         .DEPTH (MAX_COLS)
      ) u_ram (
         .clock (clock),
         .we    (issue_item && !err && wb_eff == BW'(g)),
         .waddr (col_eff[AW-1:0]),
         .wdata (wpix),
         .re    (issue_item && !err),
         .raddr (col_eff[AW-1:0]),
         .rdata (rd[g])
      );
   end

   // column vector: entry i is the row i rows above the current one
   always_comb begin
      logic [BW:0] bsel;
      for (int i = 0; i < NB; i++) begin
         bsel = {1'b0, b_wb_ff} + (BW + 1)'(NB - i);
         if (bsel >= (BW + 1)'(NB)) begin
            bsel = bsel - (BW + 1)'(NB);
         end
         if (b_zero_ff || !b_mask_ff[i]) begin
            col_pix[i] = '0;
         end else if (i == 0) begin
            col_pix[i] = b_pix_ff;
         end else begin
            col_pix[i] = rd[bsel[BW-1:0]];
         end
      end
   end

   assign col_valid = b_valid_ff;
   assign col_ctl   = b_ctl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         wb_ff        <= '0;
         flush_cnt_ff <= '0;
         b_valid_ff   <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         wb_ff        <= wb_in;
         flush_cnt_ff <= flush_cnt_in;
         b_valid_ff   <= b_valid_in;
      end
      flush_v_ff   <= flush_v_in;
      flush_row_ff <= flush_row_in;
      b_ctl_ff     <= b_ctl_in;
      b_pix_ff     <= b_pix_in;
      b_mask_ff    <= b_mask_in;
      b_wb_ff      <= b_wb_in;
      b_zero_ff    <= b_zero_in;
   end

endmodule
`default_nettype wire

// ===== rtl/cv2d_mac.sv =====
`default_nettype none
module cv2d_mac #(
   parameter int MAX_KSIZE = cv2d_pkg::DEF_MAX_KSIZE,
   parameter int FRAC_BITS = cv2d_pkg::DEF_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  col_valid,
   output logic                       col_ready,
   input  wire cv2d_pkg::col_ctl_type col_ctl,
   input  wire logic [7:0]            col_pix [MAX_KSIZE],
   input  wire logic signed [7:0]     coef [MAX_KSIZE][MAX_KSIZE],
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast
);
   import cv2d_pkg::*;

   localparam int NB = MAX_KSIZE;

   // window stage: win_ff[j][i] is column age j, row age i
   logic                      c_valid_ff, c_valid_in;
   col_ctl_type               c_ctl_ff;
   logic [7:0]                win_ff [NB][NB];
   logic [7:0]                win_in [NB][NB];
   // product stage
   logic                      d_valid_ff, d_valid_in;
   col_ctl_type               d_ctl_ff;
   logic signed [PROD_W-1:0]  prod_ff [NB][NB];
   logic signed [PROD_W-1:0]  prod_in [NB][NB];
   // row sum stage
   logic                      e_valid_ff, e_valid_in;
   col_ctl_type               e_ctl_ff;
   logic signed [ACC_W-1:0]   rsum_ff [NB];
   logic signed [ACC_W-1:0]   rsum_in [NB];
   // output register
   logic                      f_valid_ff, f_valid_in;
   logic [7:0]                f_data_ff, f_data_in;
   logic [1:0]                f_user_ff, f_user_in;
   logic                      f_last_ff, f_last_in;

   logic c_fire, d_fire, e_fire, f_fire;
   logic d_ready, e_ready, f_ready;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] acc_sh;

   assign f_ready   = !f_valid_ff || rsp_tready;
   assign e_ready   = !e_valid_ff || f_ready;
   assign d_ready   = !d_valid_ff || e_ready;
   assign col_ready = !c_valid_ff || d_ready;

   assign c_fire = col_valid && col_ready;
   assign d_fire = c_valid_ff && d_ready;
   assign e_fire = d_valid_ff && e_ready;
   assign f_fire = e_valid_ff && f_ready;

   // window shift; a row start clears the older columns
   always_comb begin
      win_in     = win_ff;
      c_valid_in = c_valid_ff;
      if (col_ready) begin
         c_valid_in = c_fire && (col_ctl.emit || col_ctl.err);
      end
      if (c_fire && !col_ctl.err) begin
         for (int j = NB - 1; j > 0; j--) begin
            for (int i = 0; i < NB; i++) begin
               win_in[j][i] = col_ctl.first ? 8'd0 : win_ff[j-1][i];
            end
         end
         for (int i = 0; i < NB; i++) begin
            win_in[0][i] = col_pix[i];
         end
      end
   end

   // products
   always_comb begin
      for (int i = 0; i < NB; i++) begin
         for (int j = 0; j < NB; j++) begin
            prod_in[i][j] = PROD_W'($signed({1'b0, win_ff[j][i]})) * PROD_W'(coef[i][j]);
         end
      end
      d_valid_in = d_ready ? d_fire : d_valid_ff;
   end

   // row sums
   always_comb begin
      for (int i = 0; i < NB; i++) begin
         rsum_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            rsum_in[i] = rsum_in[i] + ACC_W'(prod_ff[i][j]);
         end
      end
      e_valid_in = e_ready ? e_fire : e_valid_ff;
   end

   // total, shift and clamp
   always_comb begin
      acc = '0;
      for (int i = 0; i < NB; i++) begin
         acc = acc + rsum_ff[i];
      end
      acc_sh     = acc >>> FRAC_BITS;
      f_valid_in = f_valid_ff;
      f_data_in  = f_data_ff;
      f_user_in  = f_user_ff;
      f_last_in  = f_last_ff;
      if (f_ready) begin
         f_valid_in = f_fire;
         if (e_ctl_ff.err) begin
            f_data_in = '0;
            f_user_in = e_ctl_ff.status;
            f_last_in = 1'b1;
         end else begin
            if (acc <= 0) begin
               f_data_in = '0;
            end else if (acc_sh >= ACC_W'(PIX_MAX)) begin
               f_data_in = 8'(PIX_MAX);
            end else begin
               f_data_in = acc_sh[7:0];
            end
            f_user_in = ST_OK;
            f_last_in = e_ctl_ff.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
         f_valid_ff <= f_valid_in;
      end
      win_ff <= win_in;
      if (c_fire) begin
         c_ctl_ff <= col_ctl;
      end
      if (d_fire) begin
         d_ctl_ff <= c_ctl_ff;
         prod_ff  <= prod_in;
      end
      if (e_fire) begin
         e_ctl_ff <= d_ctl_ff;
         rsum_ff  <= rsum_in;
      end
      f_data_ff <= f_data_in;
      f_user_ff <= f_user_in;
      f_last_ff <= f_last_in;
   end

   assign rsp_tvalid = f_valid_ff;
   assign rsp_tdata  = f_data_ff;
   assign rsp_tuser  = f_user_ff;
   assign rsp_tlast  = f_last_ff;

endmodule
`default_nettype wire

// ===== rtl/conv2d_line_buffer_filter_unit.sv =====
// Zero-padded same-size 2D correlation over a raster pixel stream.
// req_*: one pixel per transaction, tdata = pixel, tuser = kind (0 image pixel,
// 1 drain item). After the image send (kernel side / 2) rows of drain items.
// rsp_*: one filtered pixel per transaction, tdata = pixel, tuser = status,
// tlast marks the final pixel of the image (and every error result).
// csr_*: register port, register i at byte address 8*i; write only between frames.
// Throughput: one item per cycle unless the result side stalls; at the end of
// each row that produces output, req_tready drops while the (kernel side / 2)
// zero right-hand padding columns are pushed through the window. Each of those
// columns yields at most one result; the single result port sets this rate.
// After the item that completes its window, a result passes through the bank read,
// window shift, products, row sums, and total and clamp registers.
// Reset clears all control state and loads the register defaults; the line store
// needs no clearing, as rows above the frame are masked to zero.
// A stalled receiver fills the five-stage pipeline; once full, req_tready falls.
`default_nettype none
module conv2d_line_buffer_filter_unit #(
   parameter int MAX_KSIZE = cv2d_pkg::DEF_MAX_KSIZE,
   parameter int MAX_COLS  = cv2d_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS  = cv2d_pkg::DEF_MAX_ROWS,
   parameter int FRAC_BITS = cv2d_pkg::DEF_FRAC_BITS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [7:0]                  req_tdata,   // [7:0] pixel
   input  wire logic                        req_tuser,   // [0] kind
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [7:0]                       rsp_tdata,   // [7:0] out_pixel
   output logic [1:0]                       rsp_tuser,   // [1:0] status
   output logic                             rsp_tlast,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [cv2d_pkg::CFG_AW-1:0] csr_paddr,
   input  wire logic [cv2d_pkg::CFG_DW-1:0] csr_pwdata,
   output logic      [cv2d_pkg::CFG_DW-1:0] csr_prdata,
   output logic                             csr_pready
);
   import cv2d_pkg::*;

   logic [DIM_W-1:0]  num_rows;
   logic [DIM_W-1:0]  num_cols;
   logic [KSZ_W-1:0]  ksize;
   logic signed [7:0] coef [MAX_KSIZE][MAX_KSIZE];
   logic              col_valid;
   logic              col_ready;
   col_ctl_type       col_ctl;
   logic [7:0]        col_pix [MAX_KSIZE];

   cv2d_csr #(
      .MAX_KSIZE (MAX_KSIZE)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .num_rows    (num_rows),
      .num_cols    (num_cols),
      .ksize       (ksize),
      .coef        (coef)
   );

   cv2d_seq #(
      .MAX_KSIZE (MAX_KSIZE),
      .MAX_COLS  (MAX_COLS),
      .MAX_ROWS  (MAX_ROWS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .num_rows   (num_rows),
      .num_cols   (num_cols),
      .ksize      (ksize),
      .col_valid  (col_valid),
      .col_ready  (col_ready),
      .col_ctl    (col_ctl),
      .col_pix    (col_pix)
   );

   cv2d_mac #(
      .MAX_KSIZE (MAX_KSIZE),
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .col_valid  (col_valid),
      .col_ready  (col_ready),
      .col_ctl    (col_ctl),
      .col_pix    (col_pix),
      .coef       (coef),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cv2d_pkg::*;

   localparam int KMAX     = 5;
   localparam int COLS_MAX = 1024;
   localparam int ROWS_MAX = 1024;
   localparam int SHIFT    = 6;
   localparam int HOLD_OFF = 16;
   localparam int WD_LIMIT = 4000;

   typedef struct {
      logic [7:0] pix;
      status_type status;
      logic       last;
   } filt_px_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;   // [7:0] pixel
   logic             req_tuser;   // [0] kind
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [7:0]       rsp_tdata;   // [7:0] out_pixel
   logic [1:0]       rsp_tuser;   // [1:0] status
   logic             rsp_tlast;
   logic             csr_psel;
   logic             csr_penable;
   logic             csr_pwrite;
   logic [CFG_AW-1:0] csr_paddr;
   logic [CFG_DW-1:0] csr_pwdata;
   logic [CFG_DW-1:0] csr_prdata;
   logic             csr_pready;

   conv2d_line_buffer_filter_unit DUT (.*);

   // predictor state
   logic [10:0] p_rows, p_cols;
   logic [2:0]  p_ksize;
   logic [63:0] p_kword [4];
   logic [7:0]  p_lines [KMAX][COLS_MAX];
   int unsigned p_row, p_col, p_bank;

   filt_px_type pending_pixels [$];
   int mismatches;
   int idle_pct, stall_pct;
   int idle_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int coef_at(int idx);
      logic [7:0] b;
      b = p_kword[(idx >> 3) & 3][(idx & 7) * 8 +: 8];
      return $signed(b);
   endfunction

   function automatic logic [7:0] window_sum(int oc, int k, int anchor, int ncols);
      int acc, bank, col;
      acc = 0;
      for (int kr = 0; kr < k; kr++) begin
         bank = (p_bank + KMAX - (k - 1) + kr) % KMAX;
         for (int kc = 0; kc < k; kc++) begin
            col = oc - anchor + kc;
            if (col >= 0 && col < ncols)
               acc += int'(p_lines[bank][col]) * coef_at(kr * k + kc);
         end
      end
      if (acc <= 0) return 8'd0;
      acc = acc >>> SHIFT;
      if (acc >= PIX_MAX) return 8'(PIX_MAX);
      return 8'(acc);
   endfunction

   // work out the filtered pixels caused by one accepted item
   function automatic void filter_predict(logic kind, logic [7:0] pix);
      int nr, nc, k, anchor, tail, first, lastc;
      bit have;
      filt_px_type e;
      nr = p_rows; nc = p_cols; k = p_ksize;
      e.status = ST_OK;
      if (nr == 0 || nr > ROWS_MAX) e.status = ST_BAD_ROWS;
      else if (nc == 0 || nc > COLS_MAX) e.status = ST_BAD_COLS;
      else if (k == 0 || k > KMAX) e.status = ST_BAD_KSIZE;
      if (e.status != ST_OK) begin
         p_row = 0; p_col = 0;
         e.pix = 8'd0; e.last = 1'b1;
         pending_pixels.push_back(e);
         return;
      end
      anchor = (k - 1) / 2;
      tail = k - anchor - 1;
      if (p_col >= nc || p_row >= nr + tail) begin
         p_row = 0; p_col = 0;
      end
      if (p_row == 0 && p_col == 0) begin
         foreach (p_lines[b, c]) p_lines[b][c] = 8'd0;
         p_bank = 0;
      end
      p_lines[p_bank][p_col] = (kind == 1'b0 && p_row < nr) ? pix : 8'd0;
      if (p_row >= tail) begin
         have = 0;
         if (p_col >= tail) begin
            first = p_col - tail; lastc = first; have = 1;
         end
         if (p_col == nc - 1) begin
            first = (p_col >= tail) ? p_col - tail : 0;
            lastc = nc - 1; have = 1;
         end
         if (have)
            for (int oc = first; oc <= lastc; oc++) begin
               e.pix = window_sum(oc, k, anchor, nc);
               e.last = (p_row - tail == nr - 1 && oc == nc - 1);
               pending_pixels.push_back(e);
            end
      end
      if (p_col + 1 >= nc) begin
         p_col = 0;
         p_bank = (p_bank + 1) % KMAX;
         p_row++;
         if (p_row >= nr + tail) p_row = 0;
      end else begin
         p_col++;
      end
   endfunction

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // result checker and watchdog
   always @(posedge clock) begin
      filt_px_type e;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WD_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transaction: pix %0d status %0d last %0d",
                        rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            e = pending_pixels.pop_front();
            if (rsp_tdata !== e.pix || rsp_tuser !== e.status || rsp_tlast !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp pix %0d status %0d last %0d, got %0d %0d %0d",
                           e.pix, e.status, e.last, rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // one input transaction; returns at the edge where it was taken
   task automatic send_item(logic kind, logic [7:0] pix);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      filter_predict(kind, pix);
   endtask

   // block idle: all results in, pipeline flushed
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [63:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CFG_AW'({idx, 3'b000});
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_NUM_ROWS: p_rows  = val[10:0];
         REG_NUM_COLS: p_cols  = val[10:0];
         REG_KSIZE:    p_ksize = val[2:0];
         default:      p_kword[idx - REG_KWORD0] = val;
      endcase
   endtask

   task automatic set_frame(int rows, int cols, int k);
      settle();
      write_reg(REG_NUM_ROWS, 64'(rows));
      write_reg(REG_NUM_COLS, 64'(cols));
      write_reg(REG_KSIZE, 64'(k));
   endtask

   task automatic set_kernel(logic [63:0] w0, logic [63:0] w1,
                             logic [63:0] w2, logic [63:0] w3);
      settle();
      write_reg(REG_KWORD0, w0);
      write_reg(REG_KWORD1, w1);
      write_reg(REG_KWORD2, w2);
      write_reg(REG_KWORD3, w3);
   endtask

   function automatic logic [63:0] rand_word(bit mild);
      logic [63:0] w;
      for (int i = 0; i < 8; i++)
         w[i*8 +: 8] = mild ? 8'($urandom_range(40) - 20) : 8'($urandom);
      return w;
   endfunction

   // full frame of image rows then drain rows; broken frames flip kinds or stop early
   task automatic send_frame(bit broken);
      int k, tail, total, stop;
      k = p_ksize;
      tail = (k >= 1 && k <= KMAX) ? k - (k - 1) / 2 - 1 : 0;
      total = (p_rows + tail) * p_cols;
      stop = broken && $urandom_range(1) ? $urandom_range(total) : total;
      for (int i = 0; i < stop; i++) begin
         logic kind;
         kind = (i / p_cols) >= p_rows;
         if (broken && $urandom_range(4) == 0) kind = ~kind;
         send_item(kind, 8'($urandom));
      end
   endtask

   // register defaults: one-pixel frame, zero kernel
   task automatic test_defaults();
      send_item(1'b0, 8'hFF);
      send_item(1'b1, 8'h00);
   endtask

   // each bad size check, in priority order
   task automatic test_bad_sizes();
      set_frame(0, 4, 3);    send_item(1'b0, 8'h12);
      set_frame(1025, 4, 3); send_item(1'b1, 8'h34);
      set_frame(2047, 0, 0); send_item(1'b0, 8'hFF);
      set_frame(4, 0, 3);    send_item(1'b0, 8'h01);
      set_frame(4, 2047, 3); send_item(1'b1, 8'h80);
      set_frame(4, 4, 0);    send_item(1'b0, 8'h7F);
      set_frame(4, 4, 6);    send_item(1'b0, 8'h00);
      set_frame(4, 4, 7);    send_item(1'b1, 8'hAA);
   endtask

   // unity kernel, clamping at both ends, mismatched kinds
   task automatic test_extremes();
      set_kernel(64'h40, 64'h0, 64'h0, 64'h0);
      set_frame(2, 3, 1);
      send_item(1'b0, 8'h00); send_item(1'b0, 8'hFF); send_item(1'b0, 8'h55);
      send_item(1'b1, 8'h99); send_item(1'b0, 8'hAA); send_item(1'b0, 8'h01);
      set_kernel({8{8'h7F}}, {8{8'h7F}}, {8{8'h7F}}, {8{8'h7F}});
      set_frame(2, 2, 5);
      for (int i = 0; i < 8; i++) send_item(i >= 4 ? (i == 5 ? 1'b0 : 1'b1) : 1'b0, 8'hFF);
      set_kernel({8{8'h80}}, {8{8'h80}}, {8{8'h80}}, {8{8'h80}});
      set_frame(1, 2, 3);
      for (int i = 0; i < 4; i++) send_item(i >= 2, 8'hFF);
   endtask

   // largest valid sizes: the opening items of each frame
   task automatic test_large_frames();
      set_kernel(rand_word(1), rand_word(1), rand_word(1), rand_word(1));
      set_frame(ROWS_MAX, 1, 1);
      for (int i = 0; i < 8; i++) send_item(1'b0, 8'($urandom));
      set_frame(1, COLS_MAX, 3);
      for (int i = 0; i < 8; i++) send_item(1'b0, 8'($urandom));
   endtask

   task automatic test_random_frames(int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         int k, r, c, frame_items;
         k = $urandom_range(9) == 0 ? $urandom_range(7) : $urandom_range(1, KMAX);
         r = $urandom_range(1, 6);
         c = $urandom_range(1, 10);
         set_kernel(rand_word($urandom_range(1)), rand_word($urandom_range(1)),
                    rand_word($urandom_range(1)), rand_word($urandom_range(1)));
         set_frame(r, c, k);
         if (k == 0 || k > KMAX) begin
            send_item($urandom_range(1), 8'($urandom));
            sent++;
         end else begin
            frame_items = (r + k - (k - 1) / 2 - 1) * c;
            send_frame($urandom_range(6) == 0);
            sent += frame_items;
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      idle_pct    = 0;
      stall_pct   = 0;
      mismatches  = 0;
      idle_cycles = 0;
      p_rows = 11'd1; p_cols = 11'd1; p_ksize = 3'd1;
      foreach (p_kword[i]) p_kword[i] = '0;
      foreach (p_lines[b, c]) p_lines[b][c] = 8'd0;
      p_row = 0; p_col = 0; p_bank = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults();
      test_bad_sizes();
      test_extremes();
      test_large_frames();
      test_random_frames(25);
      settle();
      idle_pct = 45; stall_pct = 0;
      test_random_frames(25);
      settle();
      idle_pct = 0; stall_pct = 45;
      test_random_frames(25);
      settle();
      idle_pct = 18; stall_pct = 18;
      test_random_frames(25);

      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire
